[rtl/core/ipc_pkg.sv]
// ipc_pkg: shared constants, register codes and types of the clamped incremental pid block
// no dependencies; used by the interfaces, the stage modules and the top level
`default_nettype none

package ipc_pkg;

	// default build widths
	localparam int MEASURE_WIDTH  = 24;
	localparam int GAIN_FRAC_BITS = 8;

	// fixed field widths
	localparam int SETPOINT_WIDTH = 17;
	localparam int GAIN_WIDTH     = 16;
	localparam int LIMIT_WIDTH    = 15;
	localparam int DRIVE_WIDTH    = 16;
	localparam int CFG_IDX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH = 16;

	// register values after reset (1.9, 1.3 and 0.7 in q8.8, limit 20)
	localparam logic [GAIN_WIDTH-1:0]  GAIN_PROP_RST  = 16'd486;
	localparam logic [GAIN_WIDTH-1:0]  GAIN_INTEG_RST = 16'd333;
	localparam logic [GAIN_WIDTH-1:0]  GAIN_DERIV_RST = 16'd179;
	localparam logic [LIMIT_WIDTH-1:0] OUT_LIMIT_RST  = 15'd20;

	// configuration register indexes
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_GAIN_PROP  = 2'd0,
		REG_GAIN_INTEG = 2'd1,
		REG_GAIN_DERIV = 2'd2,
		REG_OUT_LIMIT  = 2'd3
	} cfg_reg_t;

	// gain set handed to the multiply stage
	typedef struct packed {
		logic [GAIN_WIDTH-1:0] gain_prop;
		logic [GAIN_WIDTH-1:0] gain_integ;
		logic [GAIN_WIDTH-1:0] gain_deriv;
	} gains_t;

endpackage

`default_nettype wire

[rtl/core/ipc_if.sv]
// ipc_sample_if and ipc_result_if: valid/ready channels of the pid block
// depends on ipc_pkg for field widths
`default_nettype none

interface ipc_sample_if #(
	parameter int MEASURE_WIDTH = ipc_pkg::MEASURE_WIDTH
);
	logic                                    valid;
	logic                                    ready;
	logic signed [MEASURE_WIDTH-1:0]         measured;
	logic signed [ipc_pkg::SETPOINT_WIDTH-1:0] setpoint;

	modport source (output valid, output measured, output setpoint, input ready);
	modport sink   (input valid, input measured, input setpoint, output ready);
endinterface

interface ipc_result_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [ipc_pkg::DRIVE_WIDTH-1:0] drive;
	logic                                   saturated;

	modport source (output valid, output drive, output saturated, input ready);
	modport sink   (input valid, input drive, input saturated, output ready);
endinterface

`default_nettype wire

[rtl/core/ipc_front.sv]
// ipc_front: input register, error forming, error history and first/second differences
// depends on ipc_pkg
`default_nettype none

module ipc_front #(
	parameter int MEASURE_WIDTH = ipc_pkg::MEASURE_WIDTH
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      up_valid,
	output logic                                           up_ready,
	input  wire logic signed [MEASURE_WIDTH-1:0]           up_measured,
	input  wire logic signed [ipc_pkg::SETPOINT_WIDTH-1:0] up_setpoint,
	output logic                                           dn_valid,
	input  wire logic                                      dn_ready,
	output logic signed [MEASURE_WIDTH:0]                  dn_err,
	output logic signed [MEASURE_WIDTH+1:0]                dn_diff1,
	output logic signed [MEASURE_WIDTH+2:0]                dn_diff2
);

	localparam int EW  = MEASURE_WIDTH + 1;
	localparam int D1W = MEASURE_WIDTH + 2;
	localparam int D2W = MEASURE_WIDTH + 3;

	logic                                     v_s1;
	logic signed [MEASURE_WIDTH-1:0]          meas_s1;
	logic signed [ipc_pkg::SETPOINT_WIDTH-1:0] tgt_s1;
	logic                                     v_s2;
	logic signed [EW-1:0]                     err_s2;
	logic signed [D1W-1:0]                    diff1_s2;
	logic signed [D2W-1:0]                    diff2_s2;
	logic signed [EW-1:0]                     err_prev1_q;
	logic signed [EW-1:0]                     err_prev2_q;
	logic signed [EW-1:0]                     err;
	logic signed [D1W-1:0]                    diff1;
	logic signed [D2W-1:0]                    diff2;
	logic                                     free_s1;
	logic                                     free_s2;
	logic                                     move_s1;

	// stage handshake
	assign free_s2  = !v_s2 || dn_ready;
	assign move_s1  = v_s1 && free_s2;
	assign free_s1  = !v_s1 || free_s2;
	assign up_ready = free_s1;

	// error and its differences against the history
	always_comb begin
		err   = EW'(tgt_s1) - EW'(meas_s1);
		diff1 = D1W'(err) - D1W'(err_prev1_q);
		diff2 = D2W'(err) - (D2W'(err_prev1_q) <<< 1) + D2W'(err_prev2_q);
	end

	// valid bits and error history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			err_prev1_q <= '0;
			err_prev2_q <= '0;
		end else begin
			if (free_s1) begin
				v_s1 <= up_valid;
			end
			if (free_s2) begin
				v_s2 <= v_s1;
			end
			if (move_s1) begin
				err_prev2_q <= err_prev1_q;
				err_prev1_q <= err;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (free_s1) begin
			meas_s1 <= up_measured;
			tgt_s1  <= up_setpoint;
		end
		if (free_s2) begin
			err_s2   <= err;
			diff1_s2 <= diff1;
			diff2_s2 <= diff2;
		end
	end

	assign dn_valid = v_s2;
	assign dn_err   = err_s2;
	assign dn_diff1 = diff1_s2;
	assign dn_diff2 = diff2_s2;

endmodule

`default_nettype wire

[rtl/core/ipc_mac.sv]
// ipc_mac: three gain products, then sum with shift toward zero
// depends on ipc_pkg for the gain set type
`default_nettype none

module ipc_mac #(
	parameter int MEASURE_WIDTH  = ipc_pkg::MEASURE_WIDTH,
	parameter int GAIN_FRAC_BITS = ipc_pkg::GAIN_FRAC_BITS,
	parameter int VAL_WIDTH      = MEASURE_WIDTH + 21 - GAIN_FRAC_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ipc_pkg::gains_t                gains,
	input  wire logic                           up_valid,
	output logic                                up_ready,
	input  wire logic signed [MEASURE_WIDTH:0]  up_err,
	input  wire logic signed [MEASURE_WIDTH+1:0] up_diff1,
	input  wire logic signed [MEASURE_WIDTH+2:0] up_diff2,
	output logic                                dn_valid,
	input  wire logic                           dn_ready,
	output logic signed [VAL_WIDTH-1:0]         dn_value
);

	localparam int GW = ipc_pkg::GAIN_WIDTH;
	localparam int PW = MEASURE_WIDTH + 3 + GW;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] RND = {{(SW-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

	logic                 v_s3;
	logic signed [PW-1:0] prod_p_s3;
	logic signed [PW-1:0] prod_i_s3;
	logic signed [PW-1:0] prod_d_s3;
	logic                 v_s4;
	logic signed [VAL_WIDTH-1:0] val_s4;
	logic signed [PW-1:0] prod_p;
	logic signed [PW-1:0] prod_i;
	logic signed [PW-1:0] prod_d;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] adj;
	logic                 free_s3;
	logic                 free_s4;

	// stage handshake
	assign free_s4  = !v_s4 || dn_ready;
	assign free_s3  = !v_s3 || free_s4;
	assign up_ready = free_s3;

	// unsigned gains times signed error terms
	always_comb begin
		prod_p = PW'(up_diff1) * $signed({{(PW-GW){1'b0}}, gains.gain_prop});
		prod_i = PW'(up_err)   * $signed({{(PW-GW){1'b0}}, gains.gain_integ});
		prod_d = PW'(up_diff2) * $signed({{(PW-GW){1'b0}}, gains.gain_deriv});
	end

	// sum, then drop the fraction rounding toward zero
	always_comb begin
		sum = SW'(prod_p_s3) + SW'(prod_i_s3) + SW'(prod_d_s3);
		adj = sum + (sum[SW-1] ? RND : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (free_s3) begin
				v_s3 <= up_valid;
			end
			if (free_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3) begin
			prod_p_s3 <= prod_p;
			prod_i_s3 <= prod_i;
			prod_d_s3 <= prod_d;
		end
		if (free_s4) begin
			val_s4 <= VAL_WIDTH'(adj >>> GAIN_FRAC_BITS);
		end
	end

	assign dn_valid = v_s4;
	assign dn_value = val_s4;

endmodule

`default_nettype wire

[rtl/core/ipc_sat.sv]
// ipc_sat: symmetric clamp against out_limit and the output register
// depends on ipc_pkg for limit and drive widths
`default_nettype none

module ipc_sat #(
	parameter int VAL_WIDTH = ipc_pkg::MEASURE_WIDTH + 21 - ipc_pkg::GAIN_FRAC_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [ipc_pkg::LIMIT_WIDTH-1:0]       limit,
	input  wire logic                                  up_valid,
	output logic                                       up_ready,
	input  wire logic signed [VAL_WIDTH-1:0]           up_value,
	output logic                                       dn_valid,
	input  wire logic                                  dn_ready,
	output logic signed [ipc_pkg::DRIVE_WIDTH-1:0]     dn_drive,
	output logic                                       dn_saturated
);

	localparam int LW = ipc_pkg::LIMIT_WIDTH;
	localparam int DW = ipc_pkg::DRIVE_WIDTH;

	logic                        v_s5;
	logic signed [DW-1:0]        drive_s5;
	logic                        sat_s5;
	logic signed [VAL_WIDTH-1:0] lim_pos;
	logic signed [VAL_WIDTH-1:0] lim_neg;
	logic signed [VAL_WIDTH-1:0] clamped;
	logic                        sat;
	logic                        free_s5;

	assign free_s5  = !v_s5 || dn_ready;
	assign up_ready = free_s5;

	// clamp to plus or minus the limit
	always_comb begin
		lim_pos = $signed({{(VAL_WIDTH-LW){1'b0}}, limit});
		lim_neg = -lim_pos;
		clamped = up_value;
		sat     = 1'b0;
		if (up_value > lim_pos) begin
			clamped = lim_pos;
			sat     = 1'b1;
		end else if (up_value < lim_neg) begin
			clamped = lim_neg;
			sat     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (free_s5) begin
			v_s5 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s5) begin
			drive_s5 <= DW'(clamped);
			sat_s5   <= sat;
		end
	end

	assign dn_valid     = v_s5;
	assign dn_drive     = drive_s5;
	assign dn_saturated = sat_s5;

endmodule

`default_nettype wire

[rtl/core/incremental_pid_clamped.sv]
// incremental_pid_clamped: velocity-form pid step with symmetric output clamp
// depends on ipc_pkg, ipc_if, ipc_front, ipc_mac and ipc_sat
//
// usage
// - sample channel (valid/ready) carries one word: measured value and setpoint
// - ctrl channel (valid/ready) returns one word per sample: drive and saturated
// - cfg_we/cfg_idx/cfg_data write gain_prop, gain_integ, gain_deriv, out_limit;
//   write only while no sample is in flight
// - path: a word accepted on sample passes the input register, difference
//   register, product register, sum register and output register before it
//   shows on ctrl
// - throughput: one word per cycle while ctrl is not stalled; every stage has its own valid bit, so a
//   bubble anywhere is filled and a stalled result does not block upstream
//   stages that still have room
// - when ctrl stalls, the stalled word holds and ready ripples back stage by
//   stage; up to five words sit in the pipeline
// - reset clears all stage valid bits and both error history entries, and
//   loads gains 1.9/1.3/0.7 (q8.8) and limit 20
// - the error history advances as each word leaves the input register, so
//   words are processed strictly in order
`default_nettype none

module incremental_pid_clamped #(
	parameter int MEASURE_WIDTH  = ipc_pkg::MEASURE_WIDTH,
	parameter int GAIN_FRAC_BITS = ipc_pkg::GAIN_FRAC_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	ipc_sample_if.sink                                sample,
	ipc_result_if.source                              ctrl,
	input  wire logic                                 cfg_we,
	input  wire logic [ipc_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx,
	input  wire logic [ipc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	localparam int VW = MEASURE_WIDTH + 21 - GAIN_FRAC_BITS;

	ipc_pkg::gains_t                   gains_q;
	logic [ipc_pkg::LIMIT_WIDTH-1:0]   out_limit_q;

	logic                              f_valid;
	logic                              f_ready;
	logic signed [MEASURE_WIDTH:0]     f_err;
	logic signed [MEASURE_WIDTH+1:0]   f_diff1;
	logic signed [MEASURE_WIDTH+2:0]   f_diff2;
	logic                              m_valid;
	logic                              m_ready;
	logic signed [VW-1:0]              m_value;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.gain_prop  <= ipc_pkg::GAIN_PROP_RST;
			gains_q.gain_integ <= ipc_pkg::GAIN_INTEG_RST;
			gains_q.gain_deriv <= ipc_pkg::GAIN_DERIV_RST;
			out_limit_q        <= ipc_pkg::OUT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (ipc_pkg::cfg_reg_t'(cfg_idx))
				ipc_pkg::REG_GAIN_PROP:  gains_q.gain_prop  <= cfg_data;
				ipc_pkg::REG_GAIN_INTEG: gains_q.gain_integ <= cfg_data;
				ipc_pkg::REG_GAIN_DERIV: gains_q.gain_deriv <= cfg_data;
				ipc_pkg::REG_OUT_LIMIT:  out_limit_q <= cfg_data[ipc_pkg::LIMIT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// error and differences
	ipc_front #(
		.MEASURE_WIDTH (MEASURE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (sample.valid),
		.up_ready    (sample.ready),
		.up_measured (sample.measured),
		.up_setpoint (sample.setpoint),
		.dn_valid    (f_valid),
		.dn_ready    (f_ready),
		.dn_err      (f_err),
		.dn_diff1    (f_diff1),
		.dn_diff2    (f_diff2)
	);

	// gain products and scaled sum
	ipc_mac #(
		.MEASURE_WIDTH  (MEASURE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.VAL_WIDTH      (VW)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.gains    (gains_q),
		.up_valid (f_valid),
		.up_ready (f_ready),
		.up_err   (f_err),
		.up_diff1 (f_diff1),
		.up_diff2 (f_diff2),
		.dn_valid (m_valid),
		.dn_ready (m_ready),
		.dn_value (m_value)
	);

	// clamp and output register
	ipc_sat #(
		.VAL_WIDTH (VW)
	) u_sat (
		.clk          (clk),
		.arst_n       (arst_n),
		.limit        (out_limit_q),
		.up_valid     (m_valid),
		.up_ready     (m_ready),
		.up_value     (m_value),
		.dn_valid     (ctrl.valid),
		.dn_ready     (ctrl.ready),
		.dn_drive     (ctrl.drive),
		.dn_saturated (ctrl.saturated)
	);

endmodule

`default_nettype wire
